>>> hw/rtl/tss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// shared constants, register codes and types of the threshold spike snipper
// ----------------------------------------------------------------------------
package tss_pkg;

  // defaults of the top-level parameters
  localparam int unsigned RING_DEPTH_DEF = 128;
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // snippet command queue between scanner and readout
  localparam int unsigned QUEUE_DEPTH = 2;

  // field widths
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned WLEN_W     = 7;
  localparam int unsigned ALIGN_W    = 6;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_OFFSET = 2'd2;

  // register reset values
  localparam logic signed [THR_W-1:0] THRESHOLD_RST = 16'sd0;
  localparam logic [WLEN_W-1:0]       WINDOW_LEN_RST = 7'd32;
  localparam logic [ALIGN_W-1:0]      ALIGN_RST      = 6'd10;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [THR_W-1:0] threshold;
    logic [WLEN_W-1:0]       window_len;
    logic [ALIGN_W-1:0]      align_offset;
  } cfg_t;

  // oldest snippet still waiting to be read out of the ring
  typedef struct packed {
    logic valid;
    cnt_t start;
  } pend_t;

endpackage
`default_nettype wire

>>> hw/rtl/tss_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss interfaces
// sample input, snippet output and register write channels
// ----------------------------------------------------------------------------
interface tss_in_if;
  import tss_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TICK_W-1:0]          tick;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output tick, output sample, input ready);
  modport sink   (input valid, input tick, input sample, output ready);
endinterface

interface tss_out_if;
  import tss_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TICK_W-1:0]          out_tick;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last;
  modport source (output valid, output out_tick, output out_sample, output last, input ready);
  modport sink   (input valid, input out_tick, input out_sample, input last, output ready);
endinterface

interface tss_cfg_if;
  import tss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/threshold_spike_snipper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_spike_snipper
// threshold-crossing spike detector that streams out fixed-length snippets
// ----------------------------------------------------------------------------
// flow: a sample beat is written to the ring on acceptance; classification then
//   checks the settings and, for each candidate start tested, tests, reads and compares,
//   a hit being queued from the push state, which waits while the queue is full
// throughput: a snippet of n samples leaves at one beat a cycle while out_ready is
//   high, the first beat passing ring read and output registers; the input stalls
//   only while the oldest unread snippet start would be overwritten or a scan runs
// reset: counters and queue clear, registers reload defaults; the ring is not cleared
// ----------------------------------------------------------------------------
module threshold_spike_snipper #(
  parameter int unsigned RING_DEPTH = tss_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = tss_pkg::MAX_WINDOW_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tss_cfg_if.sink   cfg_chan,
  tss_in_if.sink    in_chan,
  tss_out_if.source out_chan
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned QW = CNT_W + AW;

  // configuration registers, always ready to take a beat
  cfg_t cfg_r;

  // effective snippet length, window clamped to the widest supported
  logic [NW-1:0] win_n;

  // ring ports
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       sa_en;
  logic [AW-1:0]              sa_addr;
  logic signed [SAMPLE_W-1:0] sa_sample;
  logic                       rb_en;
  logic [AW-1:0]              rb_addr;
  logic [TICK_W-1:0]          rb_tick;
  logic signed [SAMPLE_W-1:0] rb_sample;

  // command queue between scanner and readout
  logic          push_valid, push_ready;
  cnt_t          push_start;
  logic [AW-1:0] push_slot;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  // snippet protection: the oldest start still to be read
  pend_t busy;
  pend_t pend;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THRESHOLD_RST;
      cfg_r.window_len   <= WINDOW_LEN_RST;
      cfg_r.align_offset <= ALIGN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_THRESHOLD:    cfg_r.threshold    <= cfg_chan.data;
        REG_WINDOW_LEN:   cfg_r.window_len   <= cfg_chan.data[WLEN_W-1:0];
        REG_ALIGN_OFFSET: cfg_r.align_offset <= cfg_chan.data[ALIGN_W-1:0];
        default: begin
          // unused index, beat dropped
        end
      endcase
    end
  end

  assign win_n = (32'(cfg_r.window_len) > 32'(MAX_WINDOW)) ? NW'(MAX_WINDOW)
                                                             : NW'(cfg_r.window_len);

  // the readout holds its own start; otherwise the head of the queue
  assign pend.valid = busy.valid || pop_valid;
  assign pend.start = busy.valid ? busy.start : pop_data[QW-1:AW];

  tss_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_tick   (in_chan.tick),
    .wr_sample (in_chan.sample),
    .sa_en     (sa_en),
    .sa_addr   (sa_addr),
    .sa_sample (sa_sample),
    .rb_en     (rb_en),
    .rb_addr   (rb_addr),
    .rb_tick   (rb_tick),
    .rb_sample (rb_sample)
  );

  // front: takes sample beats and hunts for a crossing
  tss_front #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .win_n      (win_n),
    .pend       (pend),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .sa_en      (sa_en),
    .sa_addr    (sa_addr),
    .sa_sample  (sa_sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_start (push_start),
    .push_slot  (push_slot)
  );

  tss_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_start, push_slot}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: streams each queued snippet out of the ring
  tss_back #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_n      (win_n),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd_start  (pop_data[QW-1:AW]),
    .cmd_slot   (pop_data[AW-1:0]),
    .busy       (busy),
    .rb_en      (rb_en),
    .rb_addr    (rb_addr),
    .rb_tick    (rb_tick),
    .rb_sample  (rb_sample),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_tick   (out_chan.out_tick),
    .out_sample (out_chan.out_sample),
    .out_last   (out_chan.last)
  );

endmodule
`default_nettype wire

>>> hw/rtl/tss_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_ring
// sample and timestamp ring: one write port, a scan port and a readout port
// ----------------------------------------------------------------------------
module tss_ring #(
  parameter int unsigned RING_DEPTH = tss_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
  input  wire logic [tss_pkg::TICK_W-1:0]           wr_tick,
  input  wire logic signed [tss_pkg::SAMPLE_W-1:0]  wr_sample,
  input  wire logic                                 sa_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        sa_addr,
  output logic signed [tss_pkg::SAMPLE_W-1:0]       sa_sample,
  input  wire logic                                 rb_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        rb_addr,
  output logic [tss_pkg::TICK_W-1:0]                rb_tick,
  output logic signed [tss_pkg::SAMPLE_W-1:0]       rb_sample
);
  import tss_pkg::*;

  logic [TICK_W-1:0]          tick_mem   [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] sample_mem [RING_DEPTH];

  logic signed [SAMPLE_W-1:0] sa_sample_r;
  logic [TICK_W-1:0]          rb_tick_r;
  logic signed [SAMPLE_W-1:0] rb_sample_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tick_mem[wr_addr]   <= wr_tick;
      sample_mem[wr_addr] <= wr_sample;
    end
    if (sa_en) begin
      sa_sample_r <= sample_mem[sa_addr];
    end
    if (rb_en) begin
      rb_tick_r   <= tick_mem[rb_addr];
      rb_sample_r <= sample_mem[rb_addr];
    end
  end

  assign sa_sample = sa_sample_r;
  assign rb_tick   = rb_tick_r;
  assign rb_sample = rb_sample_r;

endmodule
`default_nettype wire

>>> hw/rtl/tss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_front
// accepts samples into the ring and scans candidate starts for a crossing
// ----------------------------------------------------------------------------
module tss_front #(
  parameter int unsigned RING_DEPTH = tss_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = tss_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tss_pkg::cfg_t                        cfg,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      win_n,
  input  wire tss_pkg::pend_t                       pend,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  output logic                                      wr_en,
  output logic [$clog2(RING_DEPTH)-1:0]             wr_addr,
  output logic                                      sa_en,
  output logic [$clog2(RING_DEPTH)-1:0]             sa_addr,
  input  wire logic signed [tss_pkg::SAMPLE_W-1:0]  sa_sample,
  output logic                                      push_valid,
  input  wire logic                                 push_ready,
  output tss_pkg::cnt_t                             push_start,
  output logic [$clog2(RING_DEPTH)-1:0]             push_slot
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned BW = $clog2(RING_DEPTH + 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_CHK  = 3'd1;
  localparam logic [2:0] F_TEST = 3'd2;
  localparam logic [2:0] F_RDB  = 3'd3;
  localparam logic [2:0] F_CMP  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  cnt_t                       wcnt_r, wcnt_nxt;
  cnt_t                       rcnt_r, rcnt_nxt;
  logic [AW-1:0]              wpos_r, wpos_nxt;
  logic signed [SAMPLE_W-1:0] a_r;

  cnt_t          lag;
  logic [BW-1:0] back_a;
  logic          accept;
  logic          room;
  logic          hit;
  logic signed [THR_W-1:0] thr;

  // ring slot of the sample lying back entries behind the write position
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] wp, input logic [BW-1:0] back);
    logic [BW:0] sum;
    sum = (BW+1)'(wp) + (BW+1)'(RING_DEPTH) - (BW+1)'(back);
    if (sum >= (BW+1)'(RING_DEPTH)) begin
      sum = sum - (BW+1)'(RING_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign lag    = wcnt_r - rcnt_r;
  assign back_a = lag[BW-1:0] - BW'(cfg.align_offset);
  assign thr    = cfg.threshold;

  // a pending snippet start must survive the next write
  assign room     = !pend.valid || ((wcnt_r - pend.start) < CNT_W'(RING_DEPTH));
  assign in_ready = (state_r == F_IDLE) && room;
  assign accept   = in_valid && in_ready;

  assign wr_en   = accept;
  assign wr_addr = wpos_r;

  assign hit = ((thr > 16'sd0) && (a_r <= thr) && (sa_sample > thr)) ||
               ((thr < 16'sd0) && (a_r >= thr) && (sa_sample < thr));

  assign push_start = rcnt_r;
  assign push_slot  = slot_of(wpos_r, lag[BW-1:0]);

  always_comb begin
    state_nxt  = state_r;
    wcnt_nxt   = wcnt_r;
    rcnt_nxt   = rcnt_r;
    wpos_nxt   = wpos_r;
    sa_en      = 1'b0;
    sa_addr    = slot_of(wpos_r, back_a);
    push_valid = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          wcnt_nxt  = wcnt_r + 1'b1;
          wpos_nxt  = (wpos_r == AW'(RING_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
          state_nxt = F_CHK;
        end
      end
      F_CHK: begin
        if (32'(cfg.align_offset) >= 32'(win_n)) begin
          state_nxt = F_IDLE;
        end else begin
          if (lag > CNT_W'(RING_DEPTH)) begin
            rcnt_nxt = wcnt_r - CNT_W'(RING_DEPTH);
          end
          state_nxt = F_TEST;
        end
      end
      F_TEST: begin
        if (lag > CNT_W'(win_n)) begin
          sa_en     = 1'b1;
          state_nxt = F_RDB;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_RDB: begin
        sa_en     = 1'b1;
        sa_addr   = slot_of(wpos_r, back_a - 1'b1);
        state_nxt = F_CMP;
      end
      F_CMP: begin
        if (hit) begin
          state_nxt = F_PUSH;
        end else begin
          rcnt_nxt  = rcnt_r + 1'b1;
          state_nxt = F_TEST;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          rcnt_nxt  = rcnt_r + 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wcnt_r  <= '0;
      rcnt_r  <= '0;
      wpos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      wpos_r  <= wpos_nxt;
    end
  end

  // first sample of the pair
  always_ff @(posedge clk) begin
    if (state_r == F_RDB) begin
      a_r <= sa_sample;
    end
  end

  a_scan_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_TEST) |-> ((wcnt_r - rcnt_r) <= CNT_W'(RING_DEPTH)))
    else $error("scan backlog exceeds ring depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != F_IDLE) |=> (wcnt_r == $past(wcnt_r)) || ($past(state_r) == F_IDLE))
    else $error("ring written during scan");

endmodule
`default_nettype wire

>>> hw/rtl/tss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_queue
// short fifo of snippet commands from scanner to readout
// ----------------------------------------------------------------------------
module tss_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = tss_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import tss_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree while empty");

endmodule
`default_nettype wire

>>> hw/rtl/tss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_back
// reads one snippet out of the ring per command, one beat a cycle unless out_ready stalls it
// ----------------------------------------------------------------------------
module tss_back #(
  parameter int unsigned RING_DEPTH = tss_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = tss_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      win_n,
  input  wire logic                                 cmd_valid,
  output logic                                      cmd_ready,
  input  wire tss_pkg::cnt_t                        cmd_start,
  input  wire logic [$clog2(RING_DEPTH)-1:0]        cmd_slot,
  output tss_pkg::pend_t                            busy,
  output logic                                      rb_en,
  output logic [$clog2(RING_DEPTH)-1:0]             rb_addr,
  input  wire logic [tss_pkg::TICK_W-1:0]           rb_tick,
  input  wire logic signed [tss_pkg::SAMPLE_W-1:0]  rb_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [tss_pkg::TICK_W-1:0]                out_tick,
  output logic signed [tss_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                      out_last
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(MAX_WINDOW + 1);

  logic                       active_r;
  logic [AW-1:0]              slot_r;
  logic [NW-1:0]              remaining_r;
  cnt_t                       start_r;
  logic                       s1_valid_r, s1_last_r;
  logic                       out_valid_r, out_last_r;
  logic [TICK_W-1:0]          out_tick_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic advance, issue, load;

  assign advance   = !out_valid_r || out_ready;
  assign issue     = active_r && (!s1_valid_r || advance);
  assign cmd_ready = !active_r;
  assign load      = cmd_valid && cmd_ready;

  assign rb_en   = issue;
  assign rb_addr = slot_r;

  assign busy.valid = active_r;
  assign busy.start = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (issue && (remaining_r == NW'(1))) begin
        active_r <= 1'b0;
      end
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r      <= cmd_slot;
      remaining_r <= win_n;
      start_r     <= cmd_start;
    end else if (issue) begin
      slot_r      <= (slot_r == AW'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      remaining_r <= remaining_r - 1'b1;
    end
    if (issue) begin
      s1_last_r <= (remaining_r == NW'(1));
    end
    if (advance && s1_valid_r) begin
      out_tick_r   <= rb_tick;
      out_sample_r <= rb_sample;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tick   = out_tick_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (remaining_r != '0))
    else $error("empty snippet loaded");

endmodule
`default_nettype wire

>>> bench/tb_threshold_spike_snipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_spike_snipper
// streams timestamped samples through the spike snipper under several register
// settings and checks every snippet beat against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb_threshold_spike_snipper;
  import tss_pkg::*;

  localparam int unsigned RING = RING_DEPTH_DEF;
  localparam int unsigned WMAX = MAX_WINDOW_DEF;

  // settle time for the worst scan, up to a full ring of candidates
  localparam int SETTLE_CYCLES = 450;
  // hold-off starts in the last phase, where a standing backlog gives hits
  localparam int HOLD_AT       = 385;
  localparam int HOLD_CYCLES   = 2000;
  localparam int QUIET_LIMIT   = 20000;
  localparam int REPORT_MAX    = 10;

  // random phases: level, window, alignment, sample count
  localparam int PHASES = 9;
  localparam int PH_THR [PHASES] = '{500, -800, 1, 0, 2000, 2000, 300, -1, 700};
  localparam int PH_WIN [PHASES] = '{16, 2, 2, 32, 8, 8, 64, 127, 24};
  localparam int PH_ALN [PHASES] = '{5, 0, 1, 10, 9, 3, 63, 0, 12};
  localparam int PH_CNT [PHASES] = '{45, 25, 15, 10, 132, 35, 60, 35, 40};

  typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic                       none_due;  // typed in: this sample yields no snippet
    logic signed [THR_W-1:0]    thr;
    logic [WLEN_W-1:0]          win;
    logic [ALIGN_W-1:0]         aln;
    logic [TICK_W-1:0]          tick;
    logic signed [SAMPLE_W-1:0] sample;
  } plan_row_t;

  typedef struct packed {
    logic [TICK_W-1:0]          tick;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } snip_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  tss_in_if  in_bus ();
  tss_out_if out_bus ();
  tss_cfg_if cfg_bus ();

  threshold_spike_snipper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: sample history, counters and a copy of the registers
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0]          tick_hist   [RING];
  logic signed [SAMPLE_W-1:0] sample_hist [RING];
  cnt_t                       seen_cnt;   // samples written so far
  cnt_t                       scan_cnt;   // start of the next candidate snippet
  int unsigned                hist_slot;  // slot of the next write
  logic signed [THR_W-1:0]    lvl;
  logic [WLEN_W-1:0]          win_len;
  logic [ALIGN_W-1:0]         align_pos;

  snip_beat_t snippet_beats_due [$];  // beats still owed by the block, oldest first
  snip_beat_t snippet_new [$];        // beats caused by the latest sample

  int samples_sent  = 0;
  int settings_done = 0;
  int beats_seen    = 0;
  int snippets_seen = 0;
  int errors        = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  logic hold_done   = 1'b0;

  function automatic int send_idle_pct();
    return (samples_sent < 140) ? 8 : (samples_sent < 280) ? 80 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (samples_sent < 140) ? 80 : (samples_sent < 280) ? 8 : 0;
  endfunction

  task automatic note_failure(input string what);
    if (errors < REPORT_MAX) $display("mismatch: %s", what);
    errors++;
  endtask

  // ring slot of the sample with absolute count k, 1..RING samples back
  function automatic int unsigned hist_slot_of(cnt_t k);
    cnt_t back;
    back = seen_cnt - k;
    return (hist_slot + RING - back) % RING;
  endfunction

  // store one sample, scan candidate starts in order, stop at the first crossing
  task automatic predict_snippet(input logic [TICK_W-1:0] tk,
                                 input logic signed [SAMPLE_W-1:0] smp);
    int unsigned                n;
    int unsigned                i;
    int unsigned                s;
    cnt_t                       at;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       hit;
    logic                       found;
    snip_beat_t                 bt;
    snippet_new.delete();
    tick_hist[hist_slot]   = tk;
    sample_hist[hist_slot] = smp;
    hist_slot = (hist_slot + 1) % RING;
    seen_cnt  = seen_cnt + 1;
    n = (win_len > WMAX) ? WMAX : win_len;
    // alignment at or past the window end: nothing happens, scan start stays
    if (align_pos < n) begin
      // stale backlog: only samples the ring still holds may be looked at
      if (seen_cnt - scan_cnt > RING) scan_cnt = seen_cnt - RING;
      found = 1'b0;
      while (!found && (seen_cnt - scan_cnt > n)) begin
        at  = scan_cnt + align_pos;
        a   = sample_hist[hist_slot_of(at)];
        b   = sample_hist[hist_slot_of(at + 1)];
        hit = (lvl > 0 && a <= lvl && b > lvl) || (lvl < 0 && a >= lvl && b < lvl);
        if (hit) begin
          for (i = 0; i < n; i++) begin
            s         = hist_slot_of(scan_cnt + i);
            bt.tick   = tick_hist[s];
            bt.sample = sample_hist[s];
            bt.last   = (i + 1 == n);
            snippet_new.push_back(bt);
          end
          found = 1'b1;
        end
        scan_cnt = scan_cnt + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t sample_row(logic [TICK_W-1:0] tk, int smp, logic none);
    plan_row_t r;
    r          = '0;
    r.kind     = ROW_SAMPLE;
    r.none_due = none;
    r.tick     = tk;
    r.sample   = 16'(smp);
    return r;
  endfunction

  function automatic plan_row_t settings_row(int thr, int win, int aln);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_SETTINGS;
    r.thr  = 16'(thr);
    r.win  = 7'(win);
    r.aln  = 6'(aln);
    return r;
  endfunction

  // waveform around the level: quiet noise, samples sat on the level, spikes
  // past it and the odd full-range value
  function automatic logic signed [SAMPLE_W-1:0] wave_sample(int lvl_i);
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      v = $urandom_range(0, 65535) - 32768;
    else if (lvl_i == 0)
      v = $urandom_range(0, 4000) - 2000;
    else if (roll < 15)
      v = lvl_i;
    else if (roll < 27)
      v = (lvl_i > 0) ? lvl_i + $urandom_range(1, 20000) : lvl_i - $urandom_range(1, 20000);
    else
      v = (lvl_i > 0) ? lvl_i - $urandom_range(0, 3000) : lvl_i + $urandom_range(0, 3000);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic wait_drained();
    while (snippet_beats_due.size() != 0) @(posedge clk);
  endtask

  // one sample beat, with a random gap in front of it
  task automatic send_sample(input logic [TICK_W-1:0] tk,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic none_due);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct()) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.tick   <= tk;
    in_bus.sample <= smp;
    do @(posedge clk); while (!in_bus.ready);
    samples_sent++;
    predict_snippet(tk, smp);
    if (none_due) begin
      if (snippet_new.size() != 0)
        note_failure($sformatf("row tick %h wants no snippet, predictor has %0d beats",
                               tk, snippet_new.size()));
    end else begin
      foreach (snippet_new[k]) snippet_beats_due.push_back(snippet_new[k]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_THRESHOLD:    lvl       = val;
      REG_WINDOW_LEN:   win_len   = val[WLEN_W-1:0];
      REG_ALIGN_OFFSET: align_pos = val[ALIGN_W-1:0];
      default: ;
    endcase
  endtask

  // registers change only with the block idle: every owed beat out, then time
  // for a scan that finds nothing to finish
  task automatic apply_settings(input logic signed [THR_W-1:0] thr,
                                input logic [WLEN_W-1:0] win,
                                input logic [ALIGN_W-1:0] aln);
    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WINDOW_LEN, 16'(win));
    write_reg(REG_ALIGN_OFFSET, 16'(aln));
    cfg_bus.valid <= 1'b0;
    settings_done++;
  endtask

  // --------------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off to fill the block
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && samples_sent >= HOLD_AT) begin
      out_bus.ready <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // --------------------------------------------------------------------------
  // checker: each accepted beat against the oldest owed beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : snippet_check
    snip_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      beats_seen++;
      if (out_bus.last) snippets_seen++;
      if (snippet_beats_due.size() == 0) begin
        note_failure($sformatf("beat with nothing owed: tick %h sample %0d last %b",
                               out_bus.out_tick, out_bus.out_sample, out_bus.last));
      end else begin
        want = snippet_beats_due.pop_front();
        if (out_bus.out_tick !== want.tick || out_bus.out_sample !== want.sample ||
            out_bus.last !== want.last)
          note_failure($sformatf("beat %0d: want %h/%0d/%b, got %h/%0d/%b",
                                 beats_seen, want.tick, want.sample, want.last,
                                 out_bus.out_tick, out_bus.out_sample, out_bus.last));
      end
    end
  end

  // watchdog: too long without any beat on any channel
  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled after %0d samples and %0d beats, %0d still owed",
               samples_sent, beats_seen, snippet_beats_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    plan_row_t         plan [$];
    logic [TICK_W-1:0] tk;
    logic [TICK_W-1:0] tick_next;

    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.tick    = '0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_THRESHOLD;
    cfg_bus.data   = '0;

    seen_cnt  = '0;
    scan_cnt  = '0;
    hist_slot = 0;
    lvl       = THRESHOLD_RST;
    win_len   = WINDOW_LEN_RST;
    align_pos = ALIGN_RST;
    foreach (tick_hist[k]) begin
      tick_hist[k]   = '0;
      sample_hist[k] = '0;
    end
    tick_next = $urandom;

    // straight after reset the level is zero, so nothing can ever cross
    plan.push_back(sample_row(32'h0000_0000, -32768, 1'b1));
    plan.push_back(sample_row(32'hFFFF_FFFF, 32767, 1'b1));
    plan.push_back(sample_row(32'h5555_AAAA, 0, 1'b1));
    plan.push_back(sample_row(32'hAAAA_5555, -1, 1'b1));
    // rising crossing, short window
    plan.push_back(settings_row(100, 4, 1));
    plan.push_back(sample_row(32'h0000_0100, 10, 1'b0));
    plan.push_back(sample_row(32'h0000_0101, 50, 1'b0));
    plan.push_back(sample_row(32'h0000_0102, 150, 1'b0));
    plan.push_back(sample_row(32'h0000_0103, 20, 1'b0));
    plan.push_back(sample_row(32'h0000_0104, 30, 1'b0));
    // falling crossing, including a sample sat exactly on the level
    plan.push_back(settings_row(-100, 4, 1));
    plan.push_back(sample_row(32'h0000_0200, -50, 1'b0));
    plan.push_back(sample_row(32'h0000_0201, -100, 1'b0));
    plan.push_back(sample_row(32'h0000_0202, -101, 1'b0));
    plan.push_back(sample_row(32'h0000_0203, -20, 1'b0));
    plan.push_back(sample_row(32'h0000_0204, 0, 1'b0));
    // extreme levels cannot be passed in their own direction
    plan.push_back(settings_row(32767, 2, 0));
    plan.push_back(sample_row(32'h0000_0300, 0, 1'b1));
    plan.push_back(sample_row(32'h0000_0301, 32767, 1'b1));
    plan.push_back(settings_row(-32768, 2, 0));
    plan.push_back(sample_row(32'h0000_0400, 0, 1'b1));
    plan.push_back(sample_row(32'h0000_0401, -32768, 1'b1));
    // single-sample snippets
    plan.push_back(settings_row(100, 1, 0));
    plan.push_back(sample_row(32'h0000_0500, 0, 1'b0));
    plan.push_back(sample_row(32'h0000_0501, 200, 1'b0));
    plan.push_back(sample_row(32'h0000_0502, 300, 1'b0));
    // empty window and alignment at the window end never emit
    plan.push_back(settings_row(100, 0, 0));
    plan.push_back(sample_row(32'h0000_0600, 0, 1'b1));
    plan.push_back(sample_row(32'h0000_0601, 200, 1'b1));
    plan.push_back(settings_row(100, 4, 4));
    plan.push_back(sample_row(32'h0000_0700, 0, 1'b1));
    plan.push_back(sample_row(32'h0000_0701, 200, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_SETTINGS)
        apply_settings(plan[r].thr, plan[r].win, plan[r].aln);
      else
        send_sample(plan[r].tick, plan[r].sample, plan[r].none_due);
    end

    // random phases: the over-aligned phase builds a backlog longer than the
    // ring, which the next phase must skip; window 127 is clipped to the maximum
    for (int p = 0; p < PHASES; p++) begin
      apply_settings(16'(PH_THR[p]), 7'(PH_WIN[p]), 6'(PH_ALN[p]));
      repeat (PH_CNT[p]) begin
        tk = ($urandom_range(0, 19) == 0) ? $urandom : tick_next;
        tick_next = tick_next + 1;
        send_sample(tk, wave_sample(PH_THR[p]), 1'b0);
      end
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += snippet_beats_due.size();

    $display("covered %0d samples over %0d register settings, %0d snippets in %0d beats",
             samples_sent, settings_done, snippets_seen, beats_seen);
    $display("long receiver hold-off %s, %0d failures",
             hold_done ? "taken" : "not reached", errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_if.sv
hw/rtl/tss_ring.sv
hw/rtl/tss_front.sv
hw/rtl/tss_queue.sv
hw/rtl/tss_back.sv
hw/rtl/threshold_spike_snipper.sv
bench/tb_threshold_spike_snipper.sv
